[design/ate_pkg.sv]
// shared types, constants and arctangent table for the tilt estimator
// no dependencies
`timescale 1ns / 1ps
package ate_pkg;

   localparam int SampleBits = 16;
   localparam int FracBits   = 8;
   localparam int FiltBits   = SampleBits + FracBits;
   localparam int AngleBits  = 16;
   localparam int CordSteps  = AngleBits + 2;
   localparam int CordBits   = FiltBits + 4;
   localparam int StepBits   = $clog2(CordSteps + 1);
   localparam int QDepth     = 2;

   localparam logic [0:0] CSR_FILTER_KEEP = 1'b0;
   localparam logic [0:0] CSR_ORIENT      = 1'b1;

   localparam logic [1:0] ORIENT_PORTRAIT  = 2'd0;
   localparam logic [1:0] ORIENT_UPSIDE    = 2'd1;
   localparam logic [1:0] ORIENT_LAND_RGT  = 2'd2;
   localparam logic [1:0] ORIENT_LAND_LFT  = 2'd3;

   typedef struct packed {
      logic signed [SampleBits-1:0] sx;
      logic signed [SampleBits-1:0] sy;
      logic signed [SampleBits-1:0] sz;
      logic                         calibrate;
   } item_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // negate with saturation to the largest sample
   function automatic logic signed [SampleBits-1:0] sat_neg(
      input logic signed [SampleBits-1:0] v);
      logic signed [SampleBits-1:0] r;
      if (v == {1'b1, {(SampleBits-1){1'b0}}}) r = {1'b0, {(SampleBits-1){1'b1}}};
      else r = -v;
      return r;
   endfunction

endpackage

[design/ate_front.sv]
// front end: request capture and a short queue toward the back end
// depends on ate_pkg
`timescale 1ns / 1ps
module ate_front import ate_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SampleBits-1:0] req_sample_x,
   input  logic signed [SampleBits-1:0] req_sample_y,
   input  logic signed [SampleBits-1:0] req_sample_z,
   input  logic                         req_calibrate,
   output logic                         q_valid,
   input  logic                         q_take,
   output item_type                     q_item
);
   item_type         mem_ff [QDepth];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign req_stall = (cnt_ff == 2'(QDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_take;
   assign q_item    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= '{sx: req_sample_x, sy: req_sample_y, sz: req_sample_z,
                            calibrate: req_calibrate};
      end
   end
endmodule

[design/ate_cordic.sv]
// iterative vectoring cordic atan2, one step per cycle
// depends on ate_pkg
`timescale 1ns / 1ps
module ate_cordic import ate_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [CordBits-1:0] in_y,
   input  logic signed [CordBits-1:0] in_x,
   output logic                       done,
   output logic [AngleBits-1:0]       angle
);
   typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_type;
   cstate_type                 st_ff, st_in;
   logic signed [CordBits-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]                z_ff, z_in;
   logic [StepBits-1:0]        i_ff, i_in;
   logic signed [CordBits-1:0] dx, dy;
   logic [31:0]                zr;

   // arithmetic shift is a floor shift
   assign dx = y_ff >>> i_ff;
   assign dy = x_ff >>> i_ff;
   assign zr = z_ff + (32'd1 << (31 - AngleBits));
   assign angle = zr[31 -: AngleBits];
   assign done  = (st_ff == C_DONE);

   always_comb begin
      st_in = st_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      case (st_ff)
         C_IDLE, C_DONE: begin
            if (start) begin
               i_in = '0;
               if (in_y == '0) begin
                  z_in  = (in_x < 0) ? 32'h80000000 : 32'h0;
                  st_in = C_DONE;
               end else if (in_x == '0) begin
                  z_in  = (in_y > 0) ? 32'h40000000 : 32'hC0000000;
                  st_in = C_DONE;
               end else if (in_x < 0) begin
                  x_in = -in_x; y_in = -in_y; z_in = 32'h80000000; st_in = C_RUN;
               end else begin
                  x_in = in_x; y_in = in_y; z_in = 32'h0; st_in = C_RUN;
               end
            end else if (st_ff == C_DONE) begin
               st_in = C_IDLE;
            end
         end
         C_RUN: begin
            if (!y_ff[CordBits-1]) begin
               x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + atan_entry(i_ff[4:0]);
            end else begin
               x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - atan_entry(i_ff[4:0]);
            end
            i_in = i_ff + 1'b1;
            if (i_ff == StepBits'(CordSteps - 1)) st_in = C_DONE;
         end
         default: st_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= C_IDLE;
      else st_ff <= st_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
   end
endmodule

[design/ate_back.sv]
// back end: filter, two atan2 passes, centring, rate and orientation remap
// depends on ate_pkg and ate_cordic
`timescale 1ns / 1ps
module ate_back import ate_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [8:0]                   keep_cfg,
   input  logic [1:0]                   orient_cfg,
   input  logic                         q_valid,
   output logic                         q_take,
   input  item_type                     q_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [15:0]           rsp_attitude_x,
   output logic signed [15:0]           rsp_attitude_z,
   output logic signed [15:0]           rsp_rate_x,
   output logic signed [15:0]           rsp_rate_z,
   output logic signed [15:0]           rsp_accel_out_x,
   output logic signed [15:0]           rsp_accel_out_y,
   output logic signed [15:0]           rsp_accel_out_z
);
   typedef enum logic [2:0] {B_IDLE, B_FILT, B_MUL, B_PITCH, B_ROLL, B_FIN, B_OUT}
      bstate_type;
   localparam logic [FracBits:0] One = (FracBits+1)'(1) << FracBits;
   localparam int ProdBits = FiltBits + FracBits + 3;

   bstate_type                    st_ff, st_in;
   item_type                      it_ff;
   logic signed [FiltBits-1:0]    f_ff [3];
   logic [1:0]                    ax_ff;
   logic signed [ProdBits-1:0]    p_ff;
   logic                          first_ff;
   logic                          cgo_ff, cgo_in;
   logic [AngleBits-1:0]          cp_ff, cr_ff, pp_ff, pr_ff, pitch_ff;
   logic [FracBits:0]             keep;
   logic signed [SampleBits-1:0]  smp;
   logic signed [ProdBits-1:0]    prod_in;
   logic signed [FiltBits-1:0]    fnew;
   logic                          cstart, cdone;
   logic signed [CordBits-1:0]    cy, cx;
   logic [AngleBits-1:0]          cang, pitch_c, roll_c, pcur, rcur;
   logic [AngleBits-1:0]          ax, az, rx, rz, rxx, rzz;
   logic signed [SampleBits-1:0]  gx, gy;
   logic                          out_free;

   assign keep = (keep_cfg > 9'(One)) ? One : keep_cfg[FracBits:0];

   always_comb begin
      case (ax_ff)
         2'd0:    smp = it_ff.sx;
         2'd1:    smp = it_ff.sy;
         default: smp = it_ff.sz;
      endcase
   end

   // keep*f + (one-keep)*s*one + one/2, one multiplier pair shared by the three axes
   assign prod_in = ProdBits'($signed({1'b0, keep}) * f_ff[ax_ff])
                  + ProdBits'($signed({1'b0, One - keep}) * smp) * ProdBits'(One)
                  + ProdBits'(One >> 1);
   assign fnew = FiltBits'(p_ff >>> FracBits);

   // pitch run starts as B_PITCH is entered, once all three axes are written
   assign cgo_in = (st_in == B_PITCH) && (st_ff != B_PITCH);
   assign cstart = cgo_ff || (st_ff == B_PITCH && cdone);
   assign cy = cgo_ff ? -CordBits'(f_ff[1]) : -CordBits'(f_ff[0]);
   assign cx = -CordBits'(f_ff[2]);

   ate_cordic u_cordic (
      .clock (clock), .reset (reset), .start (cstart),
      .in_y  (cy), .in_x (cx), .done (cdone), .angle (cang)
   );

   assign pitch_c = it_ff.calibrate ? pitch_ff : cp_ff;
   assign roll_c  = it_ff.calibrate ? AngleBits'(-cang) : cr_ff;
   assign pcur = pitch_ff - pitch_c;
   assign rcur = AngleBits'(-cang) - roll_c;
   assign rxx  = pp_ff - pcur;
   assign rzz  = pr_ff - rcur;

   always_comb begin
      ax = pcur; az = rcur; rx = rxx; rz = rzz; gx = it_ff.sx; gy = it_ff.sy;
      case (orient_cfg)
         ORIENT_UPSIDE: begin
            ax = -pcur; az = -rcur; rx = -rxx; rz = -rzz;
            gx = sat_neg(it_ff.sx); gy = sat_neg(it_ff.sy);
         end
         ORIENT_LAND_RGT: begin
            ax = -rcur; az = pcur; rx = -rzz; rz = rxx;
            gx = sat_neg(it_ff.sy); gy = it_ff.sx;
         end
         ORIENT_LAND_LFT: begin
            ax = rcur; az = -pcur; rx = rzz; rz = -rxx;
            gx = it_ff.sy; gy = sat_neg(it_ff.sx);
         end
         default: ;
      endcase
   end

   assign out_free = !rsp_valid || !rsp_stall;
   assign q_take   = (st_ff == B_IDLE);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         B_IDLE:  if (q_valid) st_in = B_FILT;
         B_FILT:  if (first_ff) begin
                     if (ax_ff == 2'd2) st_in = B_PITCH;
                  end else st_in = B_MUL;
         B_MUL:   st_in = (ax_ff == 2'd2) ? B_PITCH : B_FILT;
         B_PITCH: if (cdone) st_in = B_ROLL;
         B_ROLL:  if (cdone) st_in = B_FIN;
         B_FIN:   if (out_free) st_in = B_IDLE;
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_IDLE; first_ff <= 1'b1; rsp_valid <= 1'b0; cgo_ff <= 1'b0;
         cp_ff <= '0; cr_ff <= '0; pp_ff <= '0; pr_ff <= '0;
         f_ff[0] <= '0; f_ff[1] <= '0; f_ff[2] <= '0; ax_ff <= '0;
      end else begin
         st_ff <= st_in;
         cgo_ff <= cgo_in;
         rsp_valid <= (st_ff == B_FIN && out_free) || (rsp_valid && rsp_stall);
         case (st_ff)
            B_IDLE: begin
               ax_ff <= '0;
               if (q_valid) it_ff <= q_item;
            end
            B_FILT: begin
               if (first_ff) begin
                  f_ff[ax_ff] <= FiltBits'(smp) <<< FracBits;
                  ax_ff <= ax_ff + 2'd1;
                  if (ax_ff == 2'd2) first_ff <= 1'b0;
               end else p_ff <= prod_in;
            end
            B_MUL: begin
               f_ff[ax_ff] <= fnew;
               ax_ff <= ax_ff + 2'd1;
            end
            B_PITCH: if (cdone) pitch_ff <= cang;
            B_FIN: if (out_free) begin
               cp_ff <= pitch_c; cr_ff <= roll_c;
               pp_ff <= pcur; pr_ff <= rcur;
               rsp_attitude_x <= ax; rsp_attitude_z <= az;
               rsp_rate_x <= rx; rsp_rate_z <= rz;
               rsp_accel_out_x <= gx; rsp_accel_out_y <= gy;
               rsp_accel_out_z <= it_ff.sz;
            end
            default: ;
         endcase
      end
   end
endmodule

[design/accel_tilt_estimator_core.sv]
// top level of the accelerometer tilt estimator: csr registers, front and back
// depends on ate_pkg, ate_front, ate_back
//
//  channel | handshake           | payload
//  req     | req_valid/req_stall | sample x/y/z, calibrate
//  rsp     | rsp_valid/rsp_stall | attitude x/z, rate x/z, accel out x/y/z
//  csr     | csr_write_en        | csr_index, csr_wdata (9 bits)
//
// a request passes in the back end through a take state, a product state and
// a write state per axis (only a write for the first after reset), a pitch run
// and a roll run on the shared cordic, and an output state; a vector on an
// axis skips the cordic steps. the front queue holds two requests meanwhile.
// reset is synchronous and loads the filter, centres and registers defaults.
// a stalled response holds the back end in its final state.
`timescale 1ns / 1ps
module accel_tilt_estimator_core import ate_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SampleBits-1:0] req_sample_x,
   input  logic signed [SampleBits-1:0] req_sample_y,
   input  logic signed [SampleBits-1:0] req_sample_z,
   input  logic                         req_calibrate,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [15:0]           rsp_attitude_x,
   output logic signed [15:0]           rsp_attitude_z,
   output logic signed [15:0]           rsp_rate_x,
   output logic signed [15:0]           rsp_rate_z,
   output logic signed [15:0]           rsp_accel_out_x,
   output logic signed [15:0]           rsp_accel_out_y,
   output logic signed [15:0]           rsp_accel_out_z,
   input  logic                         csr_write_en,
   input  logic                         csr_index,
   input  logic [8:0]                   csr_wdata
);
   logic [8:0] keep_ff;
   logic [1:0] orient_ff;
   logic       q_valid, q_take;
   item_type   q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff   <= 9'd218;
         orient_ff <= ORIENT_PORTRAIT;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FILTER_KEEP: keep_ff   <= csr_wdata;
            CSR_ORIENT:      orient_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   ate_front u_front (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_stall (req_stall),
      .req_sample_x (req_sample_x), .req_sample_y (req_sample_y),
      .req_sample_z (req_sample_z), .req_calibrate (req_calibrate),
      .q_valid (q_valid), .q_take (q_take), .q_item (q_item)
   );

   ate_back u_back (
      .clock (clock), .reset (reset),
      .keep_cfg (keep_ff), .orient_cfg (orient_ff),
      .q_valid (q_valid), .q_take (q_take), .q_item (q_item),
      .rsp_valid (rsp_valid), .rsp_stall (rsp_stall),
      .rsp_attitude_x (rsp_attitude_x), .rsp_attitude_z (rsp_attitude_z),
      .rsp_rate_x (rsp_rate_x), .rsp_rate_z (rsp_rate_z),
      .rsp_accel_out_x (rsp_accel_out_x), .rsp_accel_out_y (rsp_accel_out_y),
      .rsp_accel_out_z (rsp_accel_out_z)
   );
endmodule
